@@ design/ecg_artifact_remover_assert.svh @@
// assertion macros for the spike remover checks
`ifndef ECG_ARTIFACT_REMOVER_ASSERT_SVH
`define ECG_ARTIFACT_REMOVER_ASSERT_SVH

// same-cycle implication, masked during reset
`define ECAR_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ecar check failed");

// next-cycle implication, masked during reset
`define ECAR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ecar check failed");

// next-cycle implication that also covers reset
`define ECAR_ASSERT_RESET(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("ecar check failed");

`endif

@@ design/ecar_pkg.sv @@
// shared types and constants for the spike remover
package ecar_pkg;

   localparam int MAX_LEN_DEF     = 4096;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int CFG_W      = 12;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CFG_W-1:0] FIRST_RATIO_RST = 12'd768;
   localparam logic [CFG_W-1:0] GLOBAL_MULT_RST = 12'd1024;
   localparam logic [CFG_W-1:0] LOCAL_MULT_RST  = 12'd512;

   localparam logic [1:0] REG_FIRST_RATIO = 2'd0;
   localparam logic [1:0] REG_GLOBAL_MULT = 2'd1;
   localparam logic [1:0] REG_LOCAL_MULT  = 2'd2;

   localparam logic [1:0] STATUS_CLEAN = 2'd0;
   localparam logic [1:0] STATUS_PASS  = 2'd1;
   localparam logic [1:0] STATUS_NONE  = 2'd2;

   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = 2;
   localparam int ARITH_W = 64;

   typedef enum logic {
      CMD_LOAD,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      logic         valid;
      cmd_kind_type kind;
      logic         last;
   } cmd_ctl_type;

   typedef enum logic {
      AR_DIV,
      AR_SQRT
   } arith_mode_type;

   typedef struct packed {
      logic           start;
      arith_mode_type mode;
   } arith_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } arith_sts_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LOAD,
      PH_CLEAN,
      PH_PASS
   } phase_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_FIN,
      BK_RA0,
      BK_RA1,
      BK_RA2,
      BK_REPAIR,
      BK_MEAN,
      BK_MEAN_WAIT,
      BK_VAR,
      BK_VDIV,
      BK_VDIV_WAIT,
      BK_SQRT,
      BK_SQRT_WAIT,
      BK_RD1,
      BK_RD2
   } back_state_type;

endpackage

@@ design/ecar_front.sv @@
// request intake: decodes each request and queues it for the back end
module ecar_front #(
   parameter int SAMPLE_BITS = ecar_pkg::SAMPLE_BITS_DEF,
   parameter int DATA_W      = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [DATA_W-1:0]        req_tdata,   // sample_in
   input  logic                     req_tuser,   // op
   input  logic                     req_tlast,   // last_in
   output ecar_pkg::cmd_ctl_type    cmd_ctl,
   output logic [SAMPLE_BITS-1:0]   cmd_sample,
   input  logic                     cmd_pop
);
   import ecar_pkg::*;

   logic [SAMPLE_BITS-1:0] smp_ff [QDEPTH];
   cmd_kind_type           kind_ff [QDEPTH];
   logic                   last_ff [QDEPTH];
   logic [QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]        count_ff, count_in;
   logic                   push, pop;
   cmd_kind_type           kind_dec;

   assign req_tready = (count_ff != (QPTR_W+1)'(QDEPTH));
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_pop && (count_ff != '0);
   assign kind_dec   = req_tuser ? CMD_READ : CMD_LOAD;

   assign cmd_ctl.valid = (count_ff != '0);
   assign cmd_ctl.kind  = kind_ff[rd_ptr_ff];
   assign cmd_ctl.last  = last_ff[rd_ptr_ff];
   assign cmd_sample    = smp_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         smp_ff[wr_ptr_ff]  <= req_tdata[SAMPLE_BITS-1:0];
         kind_ff[wr_ptr_ff] <= kind_dec;
         last_ff[wr_ptr_ff] <= req_tlast;
      end
   end

endmodule

@@ design/ecar_arith.sv @@
// shared iterative unit: restoring divider and bitwise square root
module ecar_arith #(
   parameter int DIVISOR_W = 13
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ecar_pkg::arith_req_type         ar_req,
   input  logic [ecar_pkg::ARITH_W-1:0]    ar_operand,
   input  logic [DIVISOR_W-1:0]            ar_divisor,
   output ecar_pkg::arith_sts_type         ar_sts,
   output logic [ecar_pkg::ARITH_W-1:0]    ar_result,
   output logic [DIVISOR_W-1:0]            ar_remainder
);
   import ecar_pkg::*;

   localparam int STEP_W = $clog2(ARITH_W);

   logic                 busy_ff, done_ff;
   arith_mode_type       mode_ff;
   logic [STEP_W-1:0]    step_ff;
   logic [ARITH_W-1:0]   quo_ff, x_ff, res_ff, bit_ff;
   logic [DIVISOR_W-1:0] rem_ff, dsr_ff;
   logic [DIVISOR_W:0]   trial, trial_diff;
   logic                 take;
   logic [ARITH_W-1:0]   rsum;
   logic                 sq_take;
   logic [STEP_W-1:0]    last_step;

   assign trial      = {rem_ff, quo_ff[ARITH_W-1]};
   assign trial_diff = trial - {1'b0, dsr_ff};
   assign take       = (trial >= {1'b0, dsr_ff});
   assign rsum       = res_ff + bit_ff;
   assign sq_take    = (x_ff >= rsum);
   assign last_step  = (mode_ff == AR_DIV) ? STEP_W'(ARITH_W - 1) : STEP_W'(ARITH_W/2 - 1);

   assign ar_sts.busy   = busy_ff;
   assign ar_sts.done   = done_ff;
   assign ar_result     = (mode_ff == AR_DIV) ? quo_ff : res_ff;
   assign ar_remainder  = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
         mode_ff <= AR_DIV;
      end else begin
         done_ff <= 1'b0;
         if (ar_req.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            mode_ff <= ar_req.mode;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == last_step) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ar_req.start) begin
         quo_ff <= ar_operand;
         rem_ff <= '0;
         dsr_ff <= ar_divisor;
         x_ff   <= ar_operand;
         res_ff <= '0;
         bit_ff <= ARITH_W'(1) << (ARITH_W - 2);
      end else if (busy_ff) begin
         if (mode_ff == AR_DIV) begin
            quo_ff <= {quo_ff[ARITH_W-2:0], take};
            rem_ff <= take ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         end else begin
            if (sq_take) begin
               x_ff   <= x_ff - rsum;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
      end
   end

endmodule

@@ design/ecar_back.sv @@
// execution side: sample memory, record statistics and cleaned read-out
module ecar_back #(
   parameter int MAX_LEN     = ecar_pkg::MAX_LEN_DEF,
   parameter int SAMPLE_BITS = ecar_pkg::SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ecar_pkg::cmd_ctl_type         cmd_ctl,
   input  logic [SAMPLE_BITS-1:0]        cmd_sample,
   output logic                          cmd_pop,
   input  logic [ecar_pkg::CFG_W-1:0]    first_ratio,
   input  logic [ecar_pkg::CFG_W-1:0]    global_mult,
   input  logic [ecar_pkg::CFG_W-1:0]    local_mult,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [SAMPLE_BITS-1:0]        out_sample,
   output logic                          out_replaced,
   output logic                          out_last,
   output logic [1:0]                    out_status
);
   import ecar_pkg::*;

   localparam int SB     = SAMPLE_BITS;
   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int ADDR_W = $clog2(MAX_LEN);
   localparam int SUM_W  = SB + LEN_W;
   localparam int DIFF_W = SB + 10;
   localparam int MAG_W  = SB + 8;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int DEV_W  = SB + 9;
   localparam int TH_W   = DEV_W + CFG_W;
   localparam int REP_W  = SB + 13;

   logic signed [SB-1:0] mem [MAX_LEN];
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
   logic signed [SB-1:0] mem_wdata;
   logic signed [SB-1:0] rd_data_ff;

   back_state_type        state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [LEN_W-1:0]      rp_ff, rp_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [DIFF_W-1:0] mean_ff, mean_in;
   logic [DEV_W-1:0]      dev_ff, dev_in;
   logic signed [SB-1:0]  prev_ff, prev_in;
   logic                  fixed_ff, fixed_in;
   logic signed [SB-1:0]  a0_ff, a0_in;
   logic signed [SB-1:0]  a1_ff, a1_in;
   logic [TH_W-1:0]       gth_ff, gth_in;
   logic [TH_W-1:0]       lth_ff, lth_in;
   logic [ARITH_W-1:0]    acc_ff, acc_in;
   logic [LEN_W-1:0]      iss_ff, iss_in;
   logic                  v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic [MAG_W-1:0]      d_ff, d_in;
   logic [SQ_W-1:0]       sq_ff, sq_in;
   logic                  ov_ff, ov_in;
   logic signed [SB-1:0]  os_ff, os_in;
   logic                  orep_ff, orep_in;
   logic                  olast_ff, olast_in;
   logic [1:0]            ostat_ff, ostat_in;

   arith_req_type         ar_req;
   arith_sts_type         ar_sts;
   logic [ARITH_W-1:0]    ar_operand, ar_result;
   logic [LEN_W-1:0]      ar_remainder;

   // load path
   logic [LEN_W-1:0]      ld_len;
   logic signed [SUM_W-1:0] ld_sum;

   // first-sample repair
   logic signed [SB:0]    r01, r02, r12;
   logic [SB:0]           m01, m02, m12;
   logic [REP_W-1:0]      d12_th;
   logic                  rep_hit;

   // mean
   logic [SUM_W-1:0]      sum_abs;
   logic signed [DIFF_W-1:0] mq;

   // variance pass
   logic signed [DIFF_W-1:0] vdiff;
   logic [MAG_W-1:0]      vmag;
   logic [ARITH_W:0]      acc_sum;

   // read-out
   logic [LEN_W-1:0]      rd_i, rd_ip1;
   logic signed [DIFF_W-1:0] gdiff;
   logic [MAG_W-1:0]      gmag;
   logic signed [SB:0]    dl, dr, avg_sum;
   logic [SB:0]           dlm, drm;
   logic                  g_hit, l_hit, lg_hit;
   logic signed [SB-1:0]  avg;

   ecar_arith #(
      .DIVISOR_W (LEN_W)
   ) u_ecar_arith (
      .clock        (clock),
      .reset        (reset),
      .ar_req       (ar_req),
      .ar_operand   (ar_operand),
      .ar_divisor   (len_ff),
      .ar_sts       (ar_sts),
      .ar_result    (ar_result),
      .ar_remainder (ar_remainder)
   );

   assign out_valid    = ov_ff;
   assign out_sample   = os_ff;
   assign out_replaced = orep_ff;
   assign out_last     = olast_ff;
   assign out_status   = ostat_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   assign ld_len = (phase_ff != PH_LOAD) ? '0 : len_ff;
   assign ld_sum = (phase_ff != PH_LOAD) ? '0 : sum_ff;

   assign r01     = (SB+1)'(a0_ff) - (SB+1)'(a1_ff);
   assign r02     = (SB+1)'(a0_ff) - (SB+1)'(rd_data_ff);
   assign r12     = (SB+1)'(a1_ff) - (SB+1)'(rd_data_ff);
   assign m01     = r01[SB] ? -r01 : r01;
   assign m02     = r02[SB] ? -r02 : r02;
   assign m12     = r12[SB] ? -r12 : r12;
   assign d12_th  = REP_W'(m12) * REP_W'(first_ratio);
   assign rep_hit = (REP_W'({m01, 8'b0}) > d12_th) && (REP_W'({m02, 8'b0}) > d12_th);

   assign sum_abs = sum_ff[SUM_W-1] ? -sum_ff : sum_ff;
   assign mq      = DIFF_W'(ar_result) + DIFF_W'(ar_remainder != '0);

   assign vdiff   = (DIFF_W'(rd_data_ff) <<< 8) - mean_ff;
   assign vmag    = MAG_W'(vdiff[DIFF_W-1] ? -vdiff : vdiff);
   assign acc_sum = {1'b0, acc_ff} + (ARITH_W+1)'(sq_ff);

   assign rd_i    = (rp_ff >= len_ff) ? '0 : rp_ff;
   assign rd_ip1  = rd_i + 1'b1;
   assign gdiff   = (DIFF_W'(a0_ff) <<< 8) - mean_ff;
   assign gmag    = MAG_W'(gdiff[DIFF_W-1] ? -gdiff : gdiff);
   assign dl      = (SB+1)'(a0_ff) - (SB+1)'(prev_ff);
   assign dr      = (SB+1)'(a0_ff) - (SB+1)'(rd_data_ff);
   assign dlm     = dl[SB] ? -dl : dl;
   assign drm     = dr[SB] ? -dr : dr;
   assign g_hit   = (TH_W'(gmag) << 8) > gth_ff;
   assign l_hit   = ((TH_W'(dlm) << 16) > lth_ff) && ((TH_W'(drm) << 16) > lth_ff);
   assign lg_hit  = (TH_W'(dlm) << 16) > gth_ff;
   assign avg_sum = (SB+1)'(prev_ff) + (SB+1)'(rd_data_ff);
   assign avg     = SB'(avg_sum >>> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         phase_ff <= PH_IDLE;
         len_ff   <= '0;
         rp_ff    <= '0;
         mean_ff  <= '0;
         dev_ff   <= '0;
         prev_ff  <= '0;
         fixed_ff <= 1'b0;
         ov_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         len_ff   <= len_in;
         rp_ff    <= rp_in;
         mean_ff  <= mean_in;
         dev_ff   <= dev_in;
         prev_ff  <= prev_in;
         fixed_ff <= fixed_in;
         ov_ff    <= ov_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      a0_ff    <= a0_in;
      a1_ff    <= a1_in;
      gth_ff   <= gth_in;
      lth_ff   <= lth_in;
      acc_ff   <= acc_in;
      iss_ff   <= iss_in;
      d_ff     <= d_in;
      sq_ff    <= sq_in;
      os_ff    <= os_in;
      orep_ff  <= orep_in;
      olast_ff <= olast_in;
      ostat_ff <= ostat_in;
   end

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      len_in     = len_ff;
      rp_in      = rp_ff;
      sum_in     = sum_ff;
      mean_in    = mean_ff;
      dev_in     = dev_ff;
      prev_in    = prev_ff;
      fixed_in   = fixed_ff;
      a0_in      = a0_ff;
      a1_in      = a1_ff;
      acc_in     = acc_ff;
      iss_in     = iss_ff;
      v1_in      = v1_ff;
      v2_in      = v2_ff;
      v3_in      = v3_ff;
      d_in       = d_ff;
      sq_in      = sq_ff;
      os_in      = os_ff;
      orep_in    = orep_ff;
      olast_in   = olast_ff;
      ostat_in   = ostat_ff;
      ov_in      = ov_ff && !out_ready;
      gth_in     = TH_W'(global_mult) * TH_W'(dev_ff);
      lth_in     = TH_W'(local_mult) * TH_W'(dev_ff);
      cmd_pop    = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = '0;
      mem_wdata  = $signed(cmd_sample);
      mem_raddr  = '0;
      ar_req     = '{start: 1'b0, mode: AR_DIV};
      ar_operand = acc_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_ctl.valid && cmd_ctl.kind == CMD_LOAD) begin
               cmd_pop  = 1'b1;
               phase_in = PH_LOAD;
               len_in   = ld_len;
               sum_in   = ld_sum;
               if (phase_ff != PH_LOAD) begin
                  fixed_in = 1'b0;
                  rp_in    = '0;
               end
               if (ld_len < LEN_W'(MAX_LEN)) begin
                  mem_we    = 1'b1;
                  mem_waddr = ADDR_W'(ld_len);
                  sum_in    = ld_sum + SUM_W'($signed(cmd_sample));
                  len_in    = ld_len + 1'b1;
               end
               if (cmd_ctl.last) begin
                  state_in = BK_FIN;
               end
            end else if (cmd_ctl.valid && !ov_ff) begin
               cmd_pop = 1'b1;
               if (phase_ff == PH_CLEAN || phase_ff == PH_PASS) begin
                  mem_raddr = ADDR_W'(rd_i);
                  state_in  = BK_RD1;
               end else begin
                  ov_in    = 1'b1;
                  os_in    = '0;
                  orep_in  = 1'b0;
                  olast_in = 1'b0;
                  ostat_in = STATUS_NONE;
               end
            end
         end
         BK_FIN: begin
            rp_in    = '0;
            prev_in  = '0;
            fixed_in = 1'b0;
            if (len_ff < LEN_W'(3)) begin
               phase_in = PH_PASS;
               state_in = BK_IDLE;
            end else begin
               mem_raddr = '0;
               state_in  = BK_RA0;
            end
         end
         BK_RA0: begin
            a0_in     = rd_data_ff;
            mem_raddr = ADDR_W'(1);
            state_in  = BK_RA1;
         end
         BK_RA1: begin
            a1_in     = rd_data_ff;
            mem_raddr = ADDR_W'(2);
            state_in  = BK_RA2;
         end
         BK_RA2: begin
            mem_raddr = ADDR_W'(2);
            state_in  = BK_REPAIR;
         end
         BK_REPAIR: begin
            if (rep_hit) begin
               mem_we    = 1'b1;
               mem_waddr = '0;
               mem_wdata = a1_ff;
               sum_in    = sum_ff + SUM_W'(a1_ff) - SUM_W'(a0_ff);
               fixed_in  = 1'b1;
            end
            state_in = BK_MEAN;
         end
         BK_MEAN: begin
            ar_req     = '{start: 1'b1, mode: AR_DIV};
            ar_operand = ARITH_W'({sum_abs, 8'b0});
            state_in   = BK_MEAN_WAIT;
         end
         BK_MEAN_WAIT: begin
            if (ar_sts.done) begin
               mean_in  = sum_ff[SUM_W-1] ? -mq : DIFF_W'(ar_result);
               iss_in   = '0;
               acc_in   = '0;
               v1_in    = 1'b0;
               v2_in    = 1'b0;
               v3_in    = 1'b0;
               state_in = BK_VAR;
            end
         end
         BK_VAR: begin
            if (iss_ff < len_ff) begin
               mem_raddr = ADDR_W'(iss_ff);
               iss_in    = iss_ff + 1'b1;
               v1_in     = 1'b1;
            end else begin
               v1_in = 1'b0;
            end
            d_in  = vmag;
            v2_in = v1_ff;
            sq_in = SQ_W'(d_ff) * SQ_W'(d_ff);
            v3_in = v2_ff;
            if (v3_ff) begin
               acc_in = acc_sum[ARITH_W] ? '1 : acc_sum[ARITH_W-1:0];
            end
            if (iss_ff == len_ff && !v1_ff && !v2_ff && !v3_ff) begin
               state_in = BK_VDIV;
            end
         end
         BK_VDIV: begin
            ar_req     = '{start: 1'b1, mode: AR_DIV};
            ar_operand = acc_ff;
            state_in   = BK_VDIV_WAIT;
         end
         BK_VDIV_WAIT: begin
            if (ar_sts.done) begin
               acc_in   = ar_result;
               state_in = BK_SQRT;
            end
         end
         BK_SQRT: begin
            ar_req     = '{start: 1'b1, mode: AR_SQRT};
            ar_operand = acc_ff;
            state_in   = BK_SQRT_WAIT;
         end
         BK_SQRT_WAIT: begin
            if (ar_sts.done) begin
               dev_in   = DEV_W'(ar_result);
               phase_in = (ar_result == '0) ? PH_PASS : PH_CLEAN;
               state_in = BK_IDLE;
            end
         end
         BK_RD1: begin
            a0_in     = rd_data_ff;
            mem_raddr = ADDR_W'(rd_ip1);
            state_in  = BK_RD2;
         end
         BK_RD2: begin
            os_in   = a0_ff;
            orep_in = 1'b0;
            if (rd_i == '0) begin
               orep_in = fixed_ff;
            end else if (phase_ff == PH_CLEAN) begin
               if (rd_ip1 < len_ff) begin
                  if (g_hit || l_hit) begin
                     os_in   = avg;
                     orep_in = 1'b1;
                  end
               end else if (lg_hit) begin
                  os_in   = prev_ff;
                  orep_in = 1'b1;
               end
            end
            ov_in    = 1'b1;
            olast_in = (rd_ip1 >= len_ff);
            ostat_in = (phase_ff == PH_CLEAN) ? STATUS_CLEAN : STATUS_PASS;
            prev_in  = os_in;
            rp_in    = rd_ip1;
            if (rd_ip1 >= len_ff) begin
               phase_in = PH_IDLE;
               len_in   = '0;
               rp_in    = '0;
            end
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

endmodule

@@ design/ecg_artifact_remover.sv @@
// top level of the spike remover: register block, intake queue and back end
//
// A load request writes its sample to the sample memory; the closing load then
// starts the record statistics: a repair of the first sample, the mean on the
// shared iterative unit, one pass over the sample memory for the variance, then
// the shared unit again for the variance division and the square root.
// A read request takes two reads of the sample memory and the
// replacement decision, and leaves the result in an output register. Requests
// queue four deep ahead of the back end. The sample memory is never cleared.
module ecg_artifact_remover #(
   parameter int  MAX_LEN     = ecar_pkg::MAX_LEN_DEF,
   parameter int  SAMPLE_BITS = ecar_pkg::SAMPLE_BITS_DEF,
   localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [DATA_W-1:0]                 req_tdata,   // sample_in
   input  logic                              req_tuser,   // op
   input  logic                              req_tlast,   // last_in
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [DATA_W-1:0]                 rsp_tdata,   // sample_out
   output logic [2:0]                        rsp_tuser,   // replaced, status[1:0]
   output logic                              rsp_tlast,   // last_out
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ecar_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ecar_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ecar_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import ecar_pkg::*;

   logic [CFG_W-1:0]       first_ratio_ff, first_ratio_in;
   logic [CFG_W-1:0]       global_mult_ff, global_mult_in;
   logic [CFG_W-1:0]       local_mult_ff, local_mult_in;
   logic                   csr_wr;
   logic [1:0]             csr_idx;
   cmd_ctl_type            cmd_ctl;
   logic [SAMPLE_BITS-1:0] cmd_sample;
   logic                   cmd_pop;
   logic [SAMPLE_BITS-1:0] out_sample;
   logic                   out_replaced;
   logic [1:0]             out_status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      first_ratio_in = first_ratio_ff;
      global_mult_in = global_mult_ff;
      local_mult_in  = local_mult_ff;
      csr_prdata     = '0;
      unique case (csr_idx)
         REG_FIRST_RATIO: begin
            csr_prdata = CSR_DATA_W'(first_ratio_ff);
            if (csr_wr) first_ratio_in = csr_pwdata[CFG_W-1:0];
         end
         REG_GLOBAL_MULT: begin
            csr_prdata = CSR_DATA_W'(global_mult_ff);
            if (csr_wr) global_mult_in = csr_pwdata[CFG_W-1:0];
         end
         REG_LOCAL_MULT: begin
            csr_prdata = CSR_DATA_W'(local_mult_ff);
            if (csr_wr) local_mult_in = csr_pwdata[CFG_W-1:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ratio_ff <= FIRST_RATIO_RST;
         global_mult_ff <= GLOBAL_MULT_RST;
         local_mult_ff  <= LOCAL_MULT_RST;
      end else begin
         first_ratio_ff <= first_ratio_in;
         global_mult_ff <= global_mult_in;
         local_mult_ff  <= local_mult_in;
      end
   end

   ecar_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .DATA_W      (DATA_W)
   ) u_ecar_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cmd_ctl    (cmd_ctl),
      .cmd_sample (cmd_sample),
      .cmd_pop    (cmd_pop)
   );

   ecar_back #(
      .MAX_LEN     (MAX_LEN),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ecar_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_ctl      (cmd_ctl),
      .cmd_sample   (cmd_sample),
      .cmd_pop      (cmd_pop),
      .first_ratio  (first_ratio_ff),
      .global_mult  (global_mult_ff),
      .local_mult   (local_mult_ff),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_sample   (out_sample),
      .out_replaced (out_replaced),
      .out_last     (rsp_tlast),
      .out_status   (out_status)
   );

   assign rsp_tdata = DATA_W'(out_sample);
   assign rsp_tuser = {out_status, out_replaced};

endmodule

@@ design/ecar_chk.sv @@
// port-level checks for the spike remover, bound to the top level
module ecar_chk #(
   parameter int DATA_W = 16
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic [2:0]        rsp_tuser,
   input logic              rsp_tlast
);
   import ecar_pkg::*;

   logic [1:0]        rsp_status;
   logic              rsp_stall;
   logic [DATA_W+3:0] rsp_word;
   logic              status_known;
   logic              rsp_none;
   logic              rsp_empty;

   assign rsp_status   = rsp_tuser[2:1];
   assign rsp_stall    = rsp_tvalid && !rsp_tready;
   assign rsp_word     = {rsp_tdata, rsp_tuser, rsp_tlast};
   assign status_known = (rsp_status == STATUS_CLEAN) || (rsp_status == STATUS_PASS) ||
                         (rsp_status == STATUS_NONE);
   assign rsp_none     = rsp_tvalid && (rsp_status == STATUS_NONE);
   assign rsp_empty    = (rsp_tdata == '0) && !rsp_tuser[0] && !rsp_tlast;

`include "ecg_artifact_remover_assert.svh"

   // a stalled result holds
   `ECAR_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_word))

   `ECAR_ASSERT_IMPL(a_status_code, rsp_tvalid, status_known)

   // read with no record gives an empty result
   `ECAR_ASSERT_IMPL(a_no_record, rsp_none, rsp_empty)

   `ECAR_ASSERT_RESET(a_reset_quiet, reset, !rsp_tvalid)

endmodule

bind ecg_artifact_remover ecar_chk #(.DATA_W(DATA_W)) u_ecar_chk (.*);
